### design/scl_pkg.sv
// Shared types and constants for the span-calibrated scaler.
package scl_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int CMD_W        = 3;
  localparam int SHIFT_W      = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int OUT_BITS_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CONVERT     = 3'd0,
    CMD_CAL_SAMPLE  = 3'd1,
    CMD_CAL_START   = 3'd2,
    CMD_CAL_FINISH  = 3'd3,
    CMD_LOAD_PRESET = 3'd4,
    CMD_ATTEN_SET   = 3'd5,
    CMD_ATTEN_CLEAR = 3'd6
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESET_MIN = 1'b0,
    CFG_PRESET_MAX = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low_mark;
    logic [SAMPLE_W-1:0] high_mark;
    logic [SAMPLE_W-1:0] range_width;
    logic [SHIFT_W-1:0]  atten_shift;
    logic                atten_on;
  } cal_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] preset_min;
    logic [SAMPLE_W-1:0] preset_max;
  } preset_t;

endpackage

### design/span_calibrated_u16_scaler.sv
// Top level of the span-calibrated scaler: input register, datapath, state and result register.
//
// The block accepts one command per cycle unless the output stalls and returns exactly one
// result per command. A command is captured in the input register, passes the single-pass
// datapath (offset subtract, shift and clamp, or the leading-one search for set attenuation)
// and updates the calibration state in the same cycle that its result enters the output
// register. A stalled output holds its result while one more command waits in the input
// register. Preset registers are written through the cfg_ port, by the user (not enforced) while
// no command is in flight; the load-preset command copies them into the calibration state.
module span_calibrated_u16_scaler #(
  parameter int OUT_BITS = scl_pkg::OUT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [scl_pkg::SAMPLE_W-1:0]   in_tdata,   // sample
  input  logic [scl_pkg::CMD_W-1:0]      in_tuser,   // command
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // scaled_value, span_fits, shift_in_use, zero padding
  output logic [((OUT_BITS + scl_pkg::SHIFT_W + 1 + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [scl_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [scl_pkg::SAMPLE_W-1:0]   cfg_wdata
);
  import scl_pkg::*;

  localparam int RES_W   = OUT_BITS + SHIFT_W + 1;
  localparam int TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam logic [SAMPLE_W-1:0] OUT_MAX = SAMPLE_W'((64'd1 << OUT_BITS) - 64'd1);

  logic                in_v_r;
  logic [CMD_W-1:0]    in_cmd_r;
  logic [SAMPLE_W-1:0] in_smp_r;
  logic                out_v_r;
  logic [RES_W-1:0]    out_res_r;
  cal_state_t          st_r;
  cal_state_t          st_nxt;
  preset_t             preset;
  logic [OUT_BITS-1:0] scaled_value;
  logic                span_fits;
  logic [SHIFT_W-1:0]  shift_in_use;
  logic                advance;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  scl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .preset    (preset)
  );

  scl_datapath #(
    .OUT_BITS (OUT_BITS)
  ) u_dp (
    .cmd          (in_cmd_r),
    .sample       (in_smp_r),
    .st           (st_r),
    .preset       (preset),
    .st_nxt       (st_nxt),
    .scaled_value (scaled_value),
    .span_fits    (span_fits),
    .shift_in_use (shift_in_use)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r <= in_tuser;
      in_smp_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r    <= st_nxt;
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= {shift_in_use, span_fits, scaled_value};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = TDATA_W'(out_res_r);

  // The calibration state only moves when a result is loaded, so a held result matches it.
  a_fits_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_res_r[OUT_BITS] == (st_r.range_width <= OUT_MAX)))
    else $error("span_fits disagrees with the stored span");

  a_shift_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_res_r[RES_W-1:OUT_BITS+1] != '0)) |-> st_r.atten_on)
    else $error("nonzero shift reported while attenuation is disabled");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.atten_shift <= SHIFT_W'(SAMPLE_W - OUT_BITS))
    else $error("attenuation shift out of range");

  a_cal_start: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (in_cmd_r == CMD_CAL_START)) |=>
      ((st_r.low_mark == '1) && (st_r.high_mark == '0)))
    else $error("start calibration did not reset the marks");

endmodule

### design/scl_cfg_regs.sv
// Configuration registers holding the preset minimum and maximum.
module scl_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [scl_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [scl_pkg::SAMPLE_W-1:0]  cfg_wdata,
  output scl_pkg::preset_t              preset
);
  import scl_pkg::*;

  preset_t preset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_PRESET_MIN: preset_r.preset_min <= cfg_wdata;
        CFG_PRESET_MAX: preset_r.preset_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign preset = preset_r;

endmodule

### design/scl_datapath.sv
// Single-pass command datapath: next calibration state and the result fields.
module scl_datapath #(
  parameter int OUT_BITS = scl_pkg::OUT_BITS_DEF
) (
  input  logic [scl_pkg::CMD_W-1:0]    cmd,
  input  logic [scl_pkg::SAMPLE_W-1:0] sample,
  input  scl_pkg::cal_state_t          st,
  input  scl_pkg::preset_t             preset,
  output scl_pkg::cal_state_t          st_nxt,
  output logic [OUT_BITS-1:0]          scaled_value,
  output logic                         span_fits,
  output logic [scl_pkg::SHIFT_W-1:0]  shift_in_use
);
  import scl_pkg::*;

  localparam logic [SAMPLE_W-1:0] OUT_MAX = SAMPLE_W'((64'd1 << OUT_BITS) - 64'd1);
  localparam logic [5:0]          OUT_BITS_L = 6'(OUT_BITS);

  logic [SAMPLE_W-1:0] offset;
  logic [SAMPLE_W-1:0] shifted;
  logic [5:0]          bit_len;
  logic [SHIFT_W-1:0]  fit_shift;

  always_comb begin
    bit_len = '0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (st.range_width[i]) begin
        bit_len = 6'(i + 1);
      end
    end
    fit_shift = (bit_len > OUT_BITS_L) ? SHIFT_W'(bit_len - OUT_BITS_L) : '0;
  end

  always_comb begin
    offset  = (sample > st.low_mark) ? (sample - st.low_mark) : '0;
    shifted = st.atten_on ? (offset >> st.atten_shift) : offset;
  end

  always_comb begin
    st_nxt       = st;
    scaled_value = '0;
    unique case (cmd_t'(cmd))
      CMD_CONVERT: begin
        scaled_value = (shifted > OUT_MAX) ? OUT_MAX[OUT_BITS-1:0] : shifted[OUT_BITS-1:0];
      end
      CMD_CAL_SAMPLE: begin
        if (sample > st.high_mark) begin
          st_nxt.high_mark = sample;
        end
        if (sample < st.low_mark) begin
          st_nxt.low_mark = sample;
        end
      end
      CMD_CAL_START: begin
        st_nxt.low_mark  = '1;
        st_nxt.high_mark = '0;
      end
      CMD_CAL_FINISH: begin
        st_nxt.range_width = st.high_mark - st.low_mark;
      end
      CMD_LOAD_PRESET: begin
        st_nxt.low_mark    = preset.preset_min;
        st_nxt.high_mark   = preset.preset_max;
        st_nxt.range_width = preset.preset_max - preset.preset_min;
      end
      CMD_ATTEN_SET: begin
        st_nxt.atten_shift = fit_shift;
        st_nxt.atten_on    = 1'b1;
      end
      CMD_ATTEN_CLEAR: begin
        st_nxt.atten_on = 1'b0;
      end
      default: ;
    endcase
  end

  assign span_fits    = (st_nxt.range_width <= OUT_MAX);
  assign shift_in_use = st_nxt.atten_on ? st_nxt.atten_shift : '0;

endmodule

### tb/span_calibrated_u16_scaler_tb.sv
// Self-checking testbench for the span-calibrated scaler with a built-in scoreboard.
`timescale 1ns / 1ps

module span_calibrated_u16_scaler_tb;
  import scl_pkg::*;

  localparam int RESULT_W     = ((OUT_BITS_DEF + SHIFT_W + 1 + 7) / 8) * 8;
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 100;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 65;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef struct {
    logic [15:0]        value;
    logic               fits;
    logic [SHIFT_W-1:0] shift_used;
  } reading_t;

  class reading_scoreboard;
    localparam logic [31:0] SCALED_MAX = 32'h0000_FFFF;

    logic [31:0]        preset_lo;
    logic [31:0]        preset_hi;
    logic [31:0]        lo_mark;
    logic [31:0]        hi_mark;
    logic [31:0]        span;
    logic [SHIFT_W-1:0] shift;
    logic               atten;
    reading_t           awaited[$];
    int                 mismatches;

    function new();
      preset_lo  = '0;
      preset_hi  = '0;
      lo_mark    = '0;
      hi_mark    = '0;
      span       = '0;
      shift      = '0;
      atten      = 1'b0;
      mismatches = 0;
    endfunction

    function void set_preset(cfg_idx_t idx, logic [31:0] val);
      if (idx == CFG_PRESET_MIN) begin
        preset_lo = val;
      end else begin
        preset_hi = val;
      end
    endfunction

    function automatic logic [SHIFT_W-1:0] shift_for(logic [31:0] w);
      int len;
      len = 0;
      for (int b = 0; b < 32; b++) begin
        if (w[b]) len = b + 1;
      end
      return (len > OUT_BITS_DEF) ? SHIFT_W'(len - OUT_BITS_DEF) : '0;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [31:0] smp);
      logic [31:0] diff;
      reading_t    r;
      r.value = '0;
      case (cmd)
        CMD_CONVERT: begin
          diff = (smp > lo_mark) ? smp - lo_mark : '0;
          if (atten) diff = diff >> shift;
          r.value = (diff > SCALED_MAX) ? SCALED_MAX[15:0] : diff[15:0];
        end
        CMD_CAL_SAMPLE: begin
          if (smp > hi_mark) hi_mark = smp;
          if (smp < lo_mark) lo_mark = smp;
        end
        CMD_CAL_START: begin
          lo_mark = '1;
          hi_mark = '0;
        end
        CMD_CAL_FINISH: begin
          span = hi_mark - lo_mark;
        end
        CMD_LOAD_PRESET: begin
          lo_mark = preset_lo;
          hi_mark = preset_hi;
          span    = preset_hi - preset_lo;
        end
        CMD_ATTEN_SET: begin
          shift = shift_for(span);
          atten = 1'b1;
        end
        CMD_ATTEN_CLEAR: begin
          atten = 1'b0;
        end
        default: begin
        end
      endcase
      r.fits       = (span <= SCALED_MAX);
      r.shift_used = atten ? shift : '0;
      awaited.push_back(r);
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: bad %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    task check_reading(logic [15:0] value, logic fits, logic [SHIFT_W-1:0] shift_used,
                       logic [31:0] pad);
      reading_t r;
      if (awaited.size() == 0) begin
        flag_mismatch("transfer with no result pending", 32'(value), '0);
      end else begin
        r = awaited.pop_front();
        if (value !== r.value) flag_mismatch("scaled_value", 32'(value), 32'(r.value));
        if (fits !== r.fits) flag_mismatch("span_fits", 32'(fits), 32'(r.fits));
        if (shift_used !== r.shift_used) begin
          flag_mismatch("shift_in_use", 32'(shift_used), 32'(r.shift_used));
        end
        if (pad !== '0) flag_mismatch("padding", pad, '0);
      end
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [SAMPLE_W-1:0]     in_tdata = '0;
  logic [CMD_W-1:0]        in_tuser = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [RESULT_W-1:0]     out_tdata;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_addr = '0;
  logic [SAMPLE_W-1:0]     cfg_wdata = '0;

  reading_scoreboard sb;
  bit gaps_off = 1'b0;
  bit hold_request = 1'b0;
  int sent = 0;
  int quiet_cycles = 0;

  span_calibrated_u16_scaler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit idle_roll();
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  function automatic logic [31:0] near(logic [31:0] base, int w);
    logic [31:0] mask;
    mask = (w >= 32) ? '1 : ((32'h1 << w) - 32'h1);
    return base + ($urandom & mask);
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [31:0] smp);
    while (!gaps_off && idle_roll()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, smp);
    sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_presets(input logic [31:0] lo, input logic [31:0] hi);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_PRESET_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_addr  <= CFG_PRESET_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_preset(CFG_PRESET_MIN, lo);
    sb.set_preset(CFG_PRESET_MAX, hi);
  endtask

  task automatic calib_run();
    logic [31:0] base;
    int w;
    base = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFF) : $urandom;
    w = $urandom_range(0, 32);
    send_item(CMD_CAL_START, $urandom);
    repeat ($urandom_range(1, 6)) send_item(CMD_CAL_SAMPLE, near(base, w));
    if ($urandom_range(0, 9) != 0) send_item(CMD_CAL_FINISH, $urandom);
    if ($urandom_range(0, 2) != 0) send_item(CMD_ATTEN_SET, $urandom);
    repeat ($urandom_range(2, 6)) begin
      if ($urandom_range(0, 3) == 0) begin
        send_item(CMD_CONVERT, $urandom);
      end else begin
        send_item(CMD_CONVERT, near(base - ($urandom & 32'hF), (w < 32) ? w + 1 : w));
      end
    end
  endtask

  task automatic preset_run();
    send_item(CMD_LOAD_PRESET, $urandom);
    if ($urandom_range(0, 3) != 0) send_item(CMD_ATTEN_SET, $urandom);
    repeat ($urandom_range(1, 5)) send_item(CMD_CONVERT, $urandom);
  endtask

  task automatic noise_item();
    logic [CMD_W-1:0] cmd;
    cmd = CMD_W'($urandom_range(0, 7));
    send_item(cmd, $urandom);
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_tready <= gaps_off || !idle_roll();
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_reading(out_tdata[15:0], out_tdata[16], out_tdata[21:17],
                         32'(out_tdata[RESULT_W-1:22]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int phase_start;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_CONVERT, 32'h0000_0000);
    send_item(CMD_CONVERT, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF);
    send_item(CMD_ATTEN_CLEAR, 32'h0);
    send_item(CMD_CAL_START, 32'h0);
    send_item(CMD_CAL_FINISH, 32'h0);
    send_item(CMD_ATTEN_SET, 32'h0);
    send_item(CMD_CAL_START, 32'h0);
    send_item(CMD_CAL_SAMPLE, 32'h0000_1000);
    send_item(CMD_CAL_SAMPLE, 32'h0000_0800);
    send_item(CMD_CAL_SAMPLE, 32'h0003_0000);
    send_item(CMD_CAL_FINISH, 32'h0);
    send_item(CMD_ATTEN_SET, 32'h0);
    send_item(CMD_CONVERT, 32'h0000_0800);
    send_item(CMD_CONVERT, 32'h0000_07FF);
    send_item(CMD_CONVERT, 32'hFFFF_FFFF);
    send_item(CMD_ATTEN_CLEAR, 32'h0);
    send_item(CMD_CONVERT, 32'h0001_0800);
    settle();
    write_presets(32'hFFFF_FFFF, 32'h0000_0000);
    send_item(CMD_LOAD_PRESET, 32'h0);
    send_item(CMD_ATTEN_SET, 32'h0);
    send_item(CMD_CONVERT, 32'hFFFF_FFFF);
    settle();
    write_presets(32'h0000_0000, 32'hFFFF_FFFF);
    send_item(CMD_LOAD_PRESET, 32'h0);
    send_item(CMD_ATTEN_SET, 32'h0);
    send_item(CMD_CONVERT, 32'hFFFF_FFFF);
    send_item(CMD_CONVERT, 32'h0000_0000);

    for (int phase = 0; phase < 6; phase++) begin
      logic [31:0] lo;
      settle();
      lo = $urandom;
      case (phase)
        0: write_presets(lo, $urandom);
        1: write_presets(lo, near(lo, $urandom_range(0, 20)));
        2: write_presets(32'h0000_0000, 32'h0000_FFFF);
        3: write_presets(lo, lo - ($urandom & 32'hFFFF));
        4: write_presets(32'h0000_0000, 32'h0001_0000);
        default: write_presets(lo, near(lo, 32));
      endcase
      gaps_off = (phase == 2);
      if (phase == 3) hold_request = 1'b1;
      phase_start = sent;
      while (sent - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          7: preset_run();
          8, 9: noise_item();
          default: calib_run();
        endcase
      end
    end
    gaps_off = 1'b0;

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
